FILE: sv/sdn_pkg.sv
package sdn_pkg;

   // Result fields leave the block as 16-bit two's complement.
   localparam int OUT_BITS = 16;

   // Register index on the configuration port.
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X  = 3'd0,
      CSR_CENTER_Y  = 3'd1,
      CSR_MIN_X     = 3'd2,
      CSR_MAX_X     = 3'd3,
      CSR_MIN_Y     = 3'd4,
      CSR_MAX_Y     = 3'd5,
      CSR_DEAD_ZONE = 3'd6
   } csr_index_type;

   // Per-axis status that rides along the divider stages.
   typedef struct packed {
      logic neg;    // offset below the center
      logic zero;   // offset exactly zero
      logic sat;    // span not positive, or offset reaches the span
      logic in_dz;  // offset magnitude inside the dead zone
   } sdn_flags_type;

   // What one axis lane hands to the merging stage.
   typedef struct packed {
      logic                in_dz;
      logic [OUT_BITS-1:0] value;
   } sdn_lane_out_type;

endpackage

FILE: sv/stick_deadzone_normalizer.sv
// Channel        Ports                                  Transfer
// -------------  -------------------------------------  ----------------------------------
// sample in      start, busy, req_x_raw, req_y_raw      edge with start high and busy low
// result out     rsp_valid, rsp_x_norm, rsp_y_norm,     every edge ending a cycle with
//                rsp_at_rest                            rsp_valid high
// registers      csr_valid, csr_ready, csr_index,       edge with csr_valid and csr_ready
//                csr_data                               high
//
// One sample can be accepted on every clock; busy is high during reset and for the
// first cycle after it, and low from then on.
// A result passes each lane's stage 1, stage 2, divider chain and output register and
// then the merge register; it sits on the result ports during the cycle before the edge
// that transfers it. Each axis divider chain settles one quotient bit per pipeline stage.
// Reset is synchronous and active high; it restores the calibration defaults
// and drops every sample in flight. The receiver cannot stall the result strobe.
module stick_deadzone_normalizer #(
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS   = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [SAMPLE_BITS-1:0]               req_x_raw,
   input  logic [SAMPLE_BITS-1:0]               req_y_raw,
   output logic                                 rsp_valid,
   output logic signed [sdn_pkg::OUT_BITS-1:0]  rsp_x_norm,
   output logic signed [sdn_pkg::OUT_BITS-1:0]  rsp_y_norm,
   output logic                                 rsp_at_rest,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sdn_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [SAMPLE_BITS:0]                 csr_data
);

   localparam int LATENCY = FRAC_BITS + 4;

   // Busy is held for one cycle after reset releases so nothing is accepted
   // while the pipeline valid bits are still being cleared.
   logic busy_ff;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff | reset;
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;

   // Calibration registers. Each write takes the low bits that fit the
   // register; an index past the list is dropped.
   logic [SAMPLE_BITS-1:0] center_x_ff, center_x_in;
   logic [SAMPLE_BITS-1:0] center_y_ff, center_y_in;
   logic [SAMPLE_BITS-1:0] min_x_ff, min_x_in;
   logic [SAMPLE_BITS:0]   max_x_ff, max_x_in;
   logic [SAMPLE_BITS-1:0] min_y_ff, min_y_in;
   logic [SAMPLE_BITS:0]   max_y_ff, max_y_in;
   logic [SAMPLE_BITS-1:0] dead_zone_ff, dead_zone_in;

   always_comb begin
      center_x_in  = center_x_ff;
      center_y_in  = center_y_ff;
      min_x_in     = min_x_ff;
      max_x_in     = max_x_ff;
      min_y_in     = min_y_ff;
      max_y_in     = max_y_ff;
      dead_zone_in = dead_zone_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sdn_pkg::CSR_CENTER_X:  center_x_in  = csr_data[SAMPLE_BITS-1:0];
            sdn_pkg::CSR_CENTER_Y:  center_y_in  = csr_data[SAMPLE_BITS-1:0];
            sdn_pkg::CSR_MIN_X:     min_x_in     = csr_data[SAMPLE_BITS-1:0];
            sdn_pkg::CSR_MAX_X:     max_x_in     = csr_data;
            sdn_pkg::CSR_MIN_Y:     min_y_in     = csr_data[SAMPLE_BITS-1:0];
            sdn_pkg::CSR_MAX_Y:     max_y_in     = csr_data;
            sdn_pkg::CSR_DEAD_ZONE: dead_zone_in = csr_data[SAMPLE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         center_y_ff  <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         min_x_ff     <= '0;
         max_x_ff     <= {1'b0, {SAMPLE_BITS{1'b1}}};
         min_y_ff     <= '0;
         max_y_ff     <= {1'b0, {SAMPLE_BITS{1'b1}}};
         dead_zone_ff <= '0;
      end else begin
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         min_x_ff     <= min_x_in;
         max_x_ff     <= max_x_in;
         min_y_ff     <= min_y_in;
         max_y_ff     <= max_y_in;
         dead_zone_ff <= dead_zone_in;
      end
   end

   // The two axes run in identical lanes that stay in lockstep, so the
   // merging stage only has to combine their dead-zone verdicts.
   logic                      x_valid, y_valid;
   sdn_pkg::sdn_lane_out_type x_res, y_res;

   sdn_axis_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_lane_x (
      .clock    (clock),
      .reset    (reset),
      .valid_in (accept),
      .raw      (req_x_raw),
      .lo       (min_x_ff),
      .mid      (center_x_ff),
      .hi       (max_x_ff),
      .dead_zone(dead_zone_ff),
      .valid_out(x_valid),
      .result   (x_res)
   );

   sdn_axis_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_lane_y (
      .clock    (clock),
      .reset    (reset),
      .valid_in (accept),
      .raw      (req_y_raw),
      .lo       (min_y_ff),
      .mid      (center_y_ff),
      .hi       (max_y_ff),
      .dead_zone(dead_zone_ff),
      .valid_out(y_valid),
      .result   (y_res)
   );

   // Merge stage: the stick rests only when both offsets are in the dead zone,
   // and then both axes report zero.
   logic                          rest;
   logic                          rsp_valid_ff;
   logic [sdn_pkg::OUT_BITS-1:0]  x_norm_ff, x_norm_in;
   logic [sdn_pkg::OUT_BITS-1:0]  y_norm_ff, y_norm_in;
   logic                          at_rest_ff;

   always_comb begin
      rest      = x_res.in_dz & y_res.in_dz;
      x_norm_in = rest ? '0 : x_res.value;
      y_norm_in = rest ? '0 : y_res.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= x_valid & y_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_norm_ff  <= x_norm_in;
      y_norm_ff  <= y_norm_in;
      at_rest_ff <= rest;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_norm  = $signed(x_norm_ff);
   assign rsp_y_norm  = $signed(y_norm_ff);
   assign rsp_at_rest = at_rest_ff;

`ifndef SYNTHESIS
   // Every accepted sample produces its result.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted sample produced no result");

   // No result appears without an accepted sample behind it.
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without an accepted sample");

   // The lanes never drift apart.
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      x_valid == y_valid)
      else $error("axis lanes out of step");

   // A resting stick reports a centered position on both axes.
   a_rest_centered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_rest |-> rsp_x_norm == '0 && rsp_y_norm == '0)
      else $error("resting stick reports a deflection");
`endif

endmodule

FILE: sv/sdn_div_stage.sv
module sdn_div_stage #(
   parameter int REM_BITS = 13,
   parameter int QUO_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  src_valid,
   input  sdn_pkg::sdn_flags_type src_flags,
   input  logic [REM_BITS-1:0]   src_rem,
   input  logic [REM_BITS-1:0]   src_span,
   input  logic [QUO_BITS-1:0]   src_quo,
   output logic                  dst_valid,
   output sdn_pkg::sdn_flags_type dst_flags,
   output logic [REM_BITS-1:0]   dst_rem,
   output logic [REM_BITS-1:0]   dst_span,
   output logic [QUO_BITS-1:0]   dst_quo
);

   // One restoring division step: outside the saturated cases the remainder is below the span,
   // so the doubled remainder fits one more bit and one subtract settles the bit.
   logic [REM_BITS:0]   trial;
   logic [REM_BITS+1:0] diff;
   logic                ge;

   logic                   valid_ff;
   sdn_pkg::sdn_flags_type flags_ff;
   logic [REM_BITS-1:0]    rem_ff, rem_in;
   logic [REM_BITS-1:0]    span_ff;
   logic [QUO_BITS-1:0]    quo_ff, quo_in;

   always_comb begin
      trial  = {src_rem, 1'b0};
      diff   = {1'b0, trial} - {2'b00, src_span};
      ge     = ~diff[REM_BITS+1];
      rem_in = ge ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
      quo_in = {src_quo[QUO_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= src_flags;
      rem_ff   <= rem_in;
      span_ff  <= src_span;
      quo_ff   <= quo_in;
   end

   assign dst_valid = valid_ff;
   assign dst_flags = flags_ff;
   assign dst_rem   = rem_ff;
   assign dst_span  = span_ff;
   assign dst_quo   = quo_ff;

endmodule

FILE: sv/sdn_axis_lane.sv
module sdn_axis_lane #(
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS   = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      valid_in,
   input  logic [SAMPLE_BITS-1:0]    raw,
   input  logic [SAMPLE_BITS-1:0]    lo,
   input  logic [SAMPLE_BITS-1:0]    mid,
   input  logic [SAMPLE_BITS:0]      hi,
   input  logic [SAMPLE_BITS-1:0]    dead_zone,
   output logic                      valid_out,
   output sdn_pkg::sdn_lane_out_type result
);

   localparam int S         = SAMPLE_BITS;
   localparam int REM_BITS  = SAMPLE_BITS + 1;
   localparam int VAL_BITS  = FRAC_BITS + 2;
   localparam int EXT_BITS  = (VAL_BITS > sdn_pkg::OUT_BITS) ? VAL_BITS : sdn_pkg::OUT_BITS;

   // Stage 1: offset from the center and both spans.
   logic                  v1_ff;
   logic signed [S:0]     off_ff, off_in;
   logic signed [S+1:0]   span_pos_ff, span_pos_in;
   logic signed [S+1:0]   span_neg_ff, span_neg_in;

   always_comb begin
      off_in      = $signed({1'b0, raw}) - $signed({1'b0, mid});
      span_pos_in = $signed({1'b0, hi}) - $signed({2'b00, mid});
      span_neg_in = $signed({2'b00, mid}) - $signed({2'b00, lo});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      span_pos_ff <= span_pos_in;
      span_neg_ff <= span_neg_in;
   end

   // Stage 2: magnitude, chosen span and the special-case flags.
   logic                   neg;
   logic [S:0]             abs_full;
   logic [S-1:0]           mag;
   logic signed [S+1:0]    span_sel;
   logic [S:0]             span_u;
   logic                   span_nonpos;
   sdn_pkg::sdn_flags_type flags_in;

   always_comb begin
      neg         = off_ff[S];
      abs_full    = neg ? (-off_ff) : off_ff;
      mag         = abs_full[S-1:0];
      span_sel    = neg ? span_neg_ff : span_pos_ff;
      span_u      = span_sel[S:0];
      span_nonpos = span_sel[S+1] | (span_sel == '0);
      flags_in.neg   = neg;
      flags_in.zero  = (off_ff == '0);
      flags_in.sat   = span_nonpos | ({1'b0, mag} >= span_u);
      flags_in.in_dz = (mag <= dead_zone);
   end

   logic                   v2_ff;
   sdn_pkg::sdn_flags_type flags_ff;
   logic [S:0]             rem_ff;
   logic [S:0]             span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      rem_ff   <= {1'b0, mag};
      span_ff  <= span_u;
   end

   // Divider chain: one quotient bit per stage, most significant first.
   logic                   c_valid [FRAC_BITS+1];
   sdn_pkg::sdn_flags_type c_flags [FRAC_BITS+1];
   logic [REM_BITS-1:0]    c_rem   [FRAC_BITS+1];
   logic [REM_BITS-1:0]    c_span  [FRAC_BITS+1];
   logic [FRAC_BITS-1:0]   c_quo   [FRAC_BITS+1];

   assign c_valid[0] = v2_ff;
   assign c_flags[0] = flags_ff;
   assign c_rem[0]   = rem_ff;
   assign c_span[0]  = span_ff;
   assign c_quo[0]   = '0;

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
      sdn_div_stage #(
         .REM_BITS(REM_BITS),
         .QUO_BITS(FRAC_BITS)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .src_valid(c_valid[k]),
         .src_flags(c_flags[k]),
         .src_rem  (c_rem[k]),
         .src_span (c_span[k]),
         .src_quo  (c_quo[k]),
         .dst_valid(c_valid[k+1]),
         .dst_flags(c_flags[k+1]),
         .dst_rem  (c_rem[k+1]),
         .dst_span (c_span[k+1]),
         .dst_quo  (c_quo[k+1])
      );
   end

   // Output stage: clamp, apply the sign and fit to the result width.
   sdn_pkg::sdn_flags_type   fl;
   logic [FRAC_BITS:0]       mag_q;
   logic signed [VAL_BITS-1:0] val;
   logic signed [EXT_BITS-1:0] val_ext;
   logic                      vo_ff;
   sdn_pkg::sdn_lane_out_type res_ff, res_in;

   always_comb begin
      fl = c_flags[FRAC_BITS];
      if (fl.zero) begin
         mag_q = '0;
      end else if (fl.sat) begin
         mag_q = {1'b1, {FRAC_BITS{1'b0}}};
      end else begin
         mag_q = {1'b0, c_quo[FRAC_BITS]};
      end
      val          = fl.neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
      val_ext      = EXT_BITS'(val);
      res_in.in_dz = fl.in_dz;
      res_in.value = val_ext[sdn_pkg::OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= c_valid[FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign valid_out = vo_ff;
   assign result    = res_ff;

endmodule

FILE: tb/stick_deadzone_normalizer_tb.sv
module stick_deadzone_normalizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The block turns one sample into one result.
   localparam int FRAC_BITS     = 14;
   localparam int LATENCY       = FRAC_BITS + 4;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_SAMPLES = 150;

   // Index 7 is not a register. Writes to it must leave every register alone.
   localparam logic [sdn_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      logic signed [sdn_pkg::OUT_BITS-1:0] x_norm;
      logic signed [sdn_pkg::OUT_BITS-1:0] y_norm;
      logic                                at_rest;
   } stick_position_type;

   // Keeps its own copy of the calibration registers, predicts the position for
   // every accepted sample and checks results against those predictions in order.
   class stick_scoreboard;
      localparam longint FULL_SCALE = 64'sd1 <<< FRAC_BITS;

      bit [11:0]          cen_x, cen_y, lo_x, lo_y, dz;
      bit [12:0]          hi_x, hi_y;
      stick_position_type pending_positions[$];
      int                 errors, samples, results, rest_count, full_count;

      function new();
         cen_x = 12'd2048;
         cen_y = 12'd2048;
         lo_x  = 12'd0;
         lo_y  = 12'd0;
         hi_x  = 13'd4095;
         hi_y  = 13'd4095;
         dz    = 12'd0;
      endfunction

      // Twelve-bit registers drop bit 12 of the write data.
      function void set_register(logic [sdn_pkg::CSR_INDEX_BITS-1:0] idx,
                                 logic [12:0] data);
         case (idx)
            sdn_pkg::CSR_CENTER_X:  cen_x = data[11:0];
            sdn_pkg::CSR_CENTER_Y:  cen_y = data[11:0];
            sdn_pkg::CSR_MIN_X:     lo_x  = data[11:0];
            sdn_pkg::CSR_MAX_X:     hi_x  = data;
            sdn_pkg::CSR_MIN_Y:     lo_y  = data[11:0];
            sdn_pkg::CSR_MAX_Y:     hi_y  = data;
            sdn_pkg::CSR_DEAD_ZONE: dz    = data[11:0];
            default: ;
         endcase
      endfunction

      // Offset divided by the span on its side, truncated toward zero and
      // limited to full deflection. A span that is zero or negative saturates.
      function logic signed [sdn_pkg::OUT_BITS-1:0] axis_position(longint off, longint lo,
                                                                  longint mid, longint hi);
         longint span, mag, q;
         if (off == 0) return '0;
         span = (off > 0) ? hi - mid : mid - lo;
         mag  = (off > 0) ? off : -off;
         if (span <= 0) begin
            q = FULL_SCALE;
         end else begin
            q = (mag <<< FRAC_BITS) / span;
            if (q > FULL_SCALE) q = FULL_SCALE;
         end
         if (off < 0) q = -q;
         return sdn_pkg::OUT_BITS'(q);
      endfunction

      function void note_sample(logic [11:0] x, logic [11:0] y);
         stick_position_type p;
         longint ox, oy;
         ox = longint'(x) - longint'(cen_x);
         oy = longint'(y) - longint'(cen_y);
         p.at_rest = ((ox < 0 ? -ox : ox) <= longint'(dz)) &&
                     ((oy < 0 ? -oy : oy) <= longint'(dz));
         p.x_norm  = '0;
         p.y_norm  = '0;
         if (!p.at_rest) begin
            p.x_norm = axis_position(ox, longint'(lo_x), longint'(cen_x), longint'(hi_x));
            p.y_norm = axis_position(oy, longint'(lo_y), longint'(cen_y), longint'(hi_y));
         end
         pending_positions.insert(pending_positions.size(), p);
         samples++;
      endfunction

      function void check_result(logic signed [sdn_pkg::OUT_BITS-1:0] x,
                                 logic signed [sdn_pkg::OUT_BITS-1:0] y,
                                 logic rest);
         stick_position_type p;
         results++;
         if (pending_positions.size() == 0) begin
            $display("%0t ns: result x=%0d y=%0d rest=%0b arrived with nothing pending",
                     $time, x, y, rest);
            errors++;
            return;
         end
         p = pending_positions.pop_front();
         if (x !== p.x_norm) begin
            $display("%0t ns: x_norm expected %0d, actual %0d", $time, p.x_norm, x);
            errors++;
         end
         if (y !== p.y_norm) begin
            $display("%0t ns: y_norm expected %0d, actual %0d", $time, p.y_norm, y);
            errors++;
         end
         if (rest !== p.at_rest) begin
            $display("%0t ns: at_rest expected %0b, actual %0b", $time, p.at_rest, rest);
            errors++;
         end
         if (p.at_rest) rest_count++;
         if (p.x_norm == FULL_SCALE || p.x_norm == -FULL_SCALE ||
             p.y_norm == FULL_SCALE || p.y_norm == -FULL_SCALE) full_count++;
      endfunction
   endclass

   logic                                  clock     = 1'b0;
   logic                                  reset     = 1'b1;
   logic                                  start     = 1'b0;
   logic [11:0]                           req_x_raw = '0;
   logic [11:0]                           req_y_raw = '0;
   logic                                  csr_valid = 1'b0;
   logic [sdn_pkg::CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [12:0]                           csr_data  = '0;
   logic                                  busy;
   logic                                  rsp_valid;
   logic signed [sdn_pkg::OUT_BITS-1:0]   rsp_x_norm;
   logic signed [sdn_pkg::OUT_BITS-1:0]   rsp_y_norm;
   logic                                  rsp_at_rest;
   logic                                  csr_ready;

   stick_scoreboard sb = new();
   int              idle_cycles = 0;
   int              csr_writes = 0;
   int              calibrations = 0;
   bit              no_gaps = 1'b0;

   stick_deadzone_normalizer #(
      .SAMPLE_BITS(12),
      .FRAC_BITS  (FRAC_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_x_raw  (req_x_raw),
      .req_y_raw  (req_y_raw),
      .rsp_valid  (rsp_valid),
      .rsp_x_norm (rsp_x_norm),
      .rsp_y_norm (rsp_y_norm),
      .rsp_at_rest(rsp_at_rest),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Results cannot be held off, so every strobe seen at a rising edge is a
   // transfer. Outputs are read at the edge, before the block updates them.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_x_norm, rsp_y_norm, rsp_at_rest);
   end

   // The watchdog ends the run once nothing has moved on any channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("stick_deadzone_normalizer_tb: errors");
            $finish;
         end
      end
   end

   // Mostly back-to-back or short gaps, now and then a long one. While no_gaps
   // is set the sender runs a burst with no idle cycles at all.
   function automatic int gap_length();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Every call ends at the edge where its transfer happened. start stays high
   // into the next call unless a gap is taken, so it never drops and rises in
   // the same step.
   task automatic send_sample(input logic [11:0] x, input logic [11:0] y);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_x_raw <= x;
      req_y_raw <= y;
      do @(posedge clock); while (busy);
      sb.note_sample(x, y);
   endtask

   task automatic write_register(input logic [sdn_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input logic [12:0] data);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
      csr_writes++;
   endtask

   // Stops the sample stream and waits until every predicted result is back, so
   // the registers can be changed while nothing is in flight.
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_positions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_calibration(input logic [12:0] cx, input logic [12:0] cy,
                                   input logic [12:0] lx, input logic [12:0] hx,
                                   input logic [12:0] ly, input logic [12:0] hy,
                                   input logic [12:0] dzone);
      drain();
      write_register(sdn_pkg::CSR_CENTER_X, cx);
      write_register(sdn_pkg::CSR_CENTER_Y, cy);
      write_register(sdn_pkg::CSR_MIN_X, lx);
      write_register(sdn_pkg::CSR_MAX_X, hx);
      write_register(sdn_pkg::CSR_MIN_Y, ly);
      write_register(sdn_pkg::CSR_MAX_Y, hy);
      write_register(sdn_pkg::CSR_DEAD_ZONE, dzone);
      csr_valid <= 1'b0;
      @(posedge clock);
      calibrations++;
   endtask

   // A sensible calibration most of the time: min at or below center, max at or above
   // it, and a modest dead zone. Otherwise every register takes any value its data
   // allows, which also exercises the discarded top bit on the 12-bit registers.
   task automatic random_calibration();
      int cx, cy, lx, ly, hx, hy, dzone;
      if ($urandom_range(0, 4) != 0) begin
         cx    = $urandom_range(600, 3500);
         cy    = $urandom_range(600, 3500);
         lx    = cx - int'($urandom_range(0, 600));
         ly    = cy - int'($urandom_range(0, 600));
         hx    = cx + int'($urandom_range(0, 600));
         hy    = cy + int'($urandom_range(0, 600));
         dzone = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
         // Now and then one side has no span at all.
         if ($urandom_range(0, 5) == 0) hx = cx;
         if ($urandom_range(0, 5) == 0) ly = cy;
      end else begin
         cx    = $urandom_range(0, 8191);
         cy    = $urandom_range(0, 8191);
         lx    = $urandom_range(0, 8191);
         ly    = $urandom_range(0, 8191);
         hx    = $urandom_range(0, 8191);
         hy    = $urandom_range(0, 8191);
         dzone = $urandom_range(0, 8191);
      end
      load_calibration(13'(cx), 13'(cy), 13'(lx), 13'(hx), 13'(ly), 13'(hy), 13'(dzone));
   endtask

   function automatic logic [11:0] near_point(int mid, int span);
      int v;
      v = mid + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return 12'(v);
   endfunction

   // Random samples lean toward the interesting region: around the rest point
   // and the dead-zone edge, exactly on a center, and at the extremes.
   task automatic random_sample();
      int          r, w;
      logic [11:0] x, y;
      w = int'(sb.dz) + 16;
      r = $urandom_range(0, 99);
      x = 12'($urandom_range(0, 4095));
      y = 12'($urandom_range(0, 4095));
      if (r < 35) begin
      end else if (r < 65) begin
         x = near_point(int'(sb.cen_x), w);
         y = near_point(int'(sb.cen_y), w);
      end else if (r < 75) begin
         x = sb.cen_x;
      end else if (r < 85) begin
         y = sb.cen_y;
      end else if (r < 95) begin
         if (r[0]) x = near_point(int'(sb.cen_x), w);
         else y = near_point(int'(sb.cen_y), w);
      end else begin
         x = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
         y = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      end
      send_sample(x, y);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset calibration: center 2048, full range, no dead zone, so only the
      // exact center counts as rest.
      send_sample(12'd2048, 12'd2048);
      send_sample(12'd0, 12'd0);
      send_sample(12'd4095, 12'd4095);
      send_sample(12'd0, 12'd4095);
      send_sample(12'd2047, 12'd2049);

      // A typical calibration. The center write carries a set top bit that the
      // 12-bit register must drop, and a write to the unused index changes nothing.
      load_calibration(13'h17D0, 13'd2100, 13'd100, 13'd3900, 13'd50, 13'd4000, 13'd100);
      write_register(CSR_SPARE, 13'h1FFF);
      csr_valid <= 1'b0;
      @(posedge clock);
      send_sample(12'd2000, 12'd2100);
      send_sample(12'd2100, 12'd2000);
      send_sample(12'd2101, 12'd2100);
      send_sample(12'd4095, 12'd0);
      send_sample(12'd0, 12'd4095);
      send_sample(12'd2950, 12'd1075);

      // Spans that are zero or negative on every side: any non-zero offset
      // saturates with its own sign, a zero offset still gives zero.
      load_calibration(13'd10, 13'd4000, 13'd10, 13'd5, 13'd4095, 13'd4000, 13'd0);
      send_sample(12'd20, 12'd4095);
      send_sample(12'd0, 12'd0);
      send_sample(12'd10, 12'd3999);
      send_sample(12'd4095, 12'd4000);

      // Register extremes. A dead zone of 4095 puts every sample at rest.
      load_calibration(13'd0, 13'd4095, 13'd4095, 13'd8191, 13'd0, 13'd8191, 13'd4095);
      send_sample(12'd0, 12'd0);
      send_sample(12'd4095, 12'd4095);
      send_sample(12'd4095, 12'd0);

      // Same extremes without a dead zone: a wide positive span and a zero offset.
      load_calibration(13'd0, 13'd4095, 13'd4095, 13'd8191, 13'd0, 13'd8191, 13'd0);
      send_sample(12'd4095, 12'd4095);
      send_sample(12'd0, 12'd0);

      // Random calibrations, each followed by a stream of random samples that
      // alternates between gapless bursts and irregular spacing.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_calibration();
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if (n % 32 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            random_sample();
         end
      end
      no_gaps = 1'b0;

      drain();
      repeat (LATENCY + 4) @(posedge clock);
      sb.errors += sb.pending_positions.size();

      $display("Covered %0d samples under %0d calibrations with %0d register writes.",
               sb.samples, calibrations, csr_writes);
      $display("Checked %0d results: %0d at rest, %0d with an axis at full deflection.",
               sb.results, sb.rest_count, sb.full_count);
      if (sb.errors == 0) begin
         $display("stick_deadzone_normalizer_tb: clean");
      end else begin
         $display("stick_deadzone_normalizer_tb: errors");
      end
      $finish;
   end

endmodule
